// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the scrolling rate histogram.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SRH_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays live through reset.
`define SRH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/srh_pkg.sv -----
// Shared types and constants for the scrolling rate histogram.
// Used by the register block, controller, datapath, top level and checker.
package srh_pkg;

  localparam int BIN_COUNT_DEF = 1024;
  localparam int BIN_WIDTH_DEF = 48;

  localparam int INDEX_W  = 10;
  localparam int COUNTS_W = 32;
  localparam int TIME_W   = 32;
  localparam int TOTAL_W  = 48;
  localparam int LAST_W   = 31;
  localparam int WIDE_W   = 64;

  localparam int LIMIT_W = 10;
  localparam int STEP_W  = 8;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] GARBAGE_LIMIT_RST    = LIMIT_W'(1000);
  localparam logic [LIMIT_W-1:0] SCROLL_THRESHOLD_RST = LIMIT_W'(960);
  localparam logic [STEP_W-1:0]  SCROLL_STEP_RST      = STEP_W'(60);

  typedef enum logic [1:0] {
    REG_GARBAGE_LIMIT    = 2'd0,
    REG_SCROLL_THRESHOLD = 2'd1,
    REG_SCROLL_STEP      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] garbage_limit;
    logic [LIMIT_W-1:0] scroll_threshold;
    logic [STEP_W-1:0]  scroll_step;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic clear_mem;
    logic set_offset;
    logic apply_limit;
    logic apply_scroll;
    logic scroll_clear;
    logic calc_addr;
    logic mem_read;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_positive;
    logic need_scroll;
    logic scroll_done;
    logic clear_last;
  } stat_t;

endpackage

// ----- sv/scrolling_rate_histogram_core.sv -----
// Scrolling rate histogram: one bin per second, scaler counts binned by event time.
// Accept to done: a reject passes decode and finish; a read passes decode, address, memory
// read and finish; an event adds limit and scroll check, and a scroll sweep when it scrolls.
// The next transaction is accepted in the cycle done is high. A scroll sweep clears one bin
// per cycle. Reset: synchronous rst; then a pass over every bin zeroes the bin memory with
// busy high. Results are strobed by done for one cycle; the receiver cannot stall.
module scrolling_rate_histogram_core #(
  parameter int BIN_COUNT = srh_pkg::BIN_COUNT_DEF,
  parameter int BIN_WIDTH = srh_pkg::BIN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic signed [srh_pkg::COUNTS_W-1:0] counts,
  input  logic [srh_pkg::TIME_W-1:0]          time_seconds,
  input  logic [srh_pkg::INDEX_W-1:0]         read_index,
  // result channel
  output logic                                done,
  output logic                                accepted,
  output logic                                scrolled,
  output logic [srh_pkg::INDEX_W-1:0]         bin_index,
  output logic [srh_pkg::TOTAL_W-1:0]         bin_total,
  output logic signed [srh_pkg::COUNTS_W-1:0] difference,
  output logic [srh_pkg::LAST_W-1:0]          last_counts,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srh_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [srh_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [srh_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import srh_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Register access never waits.
  assign pready = 1'b1;

  // Configuration registers; the user must write them only between transactions, the block does not enforce it.
  srh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Sequencer: reset sweep, then decode -> offset -> limit -> scroll -> update.
  srh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Origin and ring base tracking, bin memory, saturating add and result registers.
  srh_dpath #(
    .BIN_COUNT (BIN_COUNT),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .operation    (operation),
    .counts       (counts),
    .time_seconds (time_seconds),
    .read_index   (read_index),
    .stat         (stat),
    .done         (done),
    .accepted     (accepted),
    .scrolled     (scrolled),
    .bin_index    (bin_index),
    .bin_total    (bin_total),
    .difference   (difference),
    .last_counts  (last_counts)
  );

endmodule

// ----- sv/srh_regs.sv -----
// APB configuration registers of the scrolling rate histogram.
// Depends on srh_pkg.
module srh_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srh_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srh_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srh_pkg::APB_DATA_W-1:0]   prdata,
  output srh_pkg::cfg_t                    cfg
);
  import srh_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.garbage_limit    <= GARBAGE_LIMIT_RST;
      cfg.scroll_threshold <= SCROLL_THRESHOLD_RST;
      cfg.scroll_step      <= SCROLL_STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GARBAGE_LIMIT:    cfg.garbage_limit    <= pwdata[LIMIT_W-1:0];
        REG_SCROLL_THRESHOLD: cfg.scroll_threshold <= pwdata[LIMIT_W-1:0];
        REG_SCROLL_STEP:      cfg.scroll_step      <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GARBAGE_LIMIT:    prdata = APB_DATA_W'(cfg.garbage_limit);
      REG_SCROLL_THRESHOLD: prdata = APB_DATA_W'(cfg.scroll_threshold);
      REG_SCROLL_STEP:      prdata = APB_DATA_W'(cfg.scroll_step);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- sv/srh_ctrl.sv -----
// Sequencing state machine of the scrolling rate histogram.
// Depends on srh_pkg; drives the datapath through cmd_t and watches stat_t.
module srh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  srh_pkg::stat_t stat,
  output srh_pkg::cmd_t  cmd,
  output logic           busy
);
  import srh_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_LIMIT  = 9'b000001000,
    S_SCRCHK = 9'b000010000,
    S_SCROLL = 9'b000100000,
    S_ADDR   = 9'b001000000,
    S_RDMEM  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_mem = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_read) begin
          state_next = S_ADDR;
        end else if (!stat.is_positive) begin
          state_next = S_FINISH;
        end else begin
          cmd.set_offset = 1'b1;
          state_next     = S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd.apply_limit = 1'b1;
        state_next      = S_SCRCHK;
      end
      S_SCRCHK: begin
        if (stat.need_scroll) begin
          cmd.apply_scroll = 1'b1;
          state_next       = S_SCROLL;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_SCROLL: begin
        if (stat.scroll_done) begin
          state_next = S_ADDR;
        end else begin
          cmd.scroll_clear = 1'b1;
        end
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_next    = S_RDMEM;
      end
      S_RDMEM: begin
        cmd.mem_read = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- sv/srh_dpath.sv -----
// Datapath of the scrolling rate histogram: origin, ring base, bin memory, results.
// Depends on srh_pkg; steered by cmd_t from srh_ctrl.
module srh_dpath #(
  parameter int BIN_COUNT = srh_pkg::BIN_COUNT_DEF,
  parameter int BIN_WIDTH = srh_pkg::BIN_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  srh_pkg::cmd_t                     cmd,
  input  srh_pkg::cfg_t                     cfg,
  input  logic                              operation,
  input  logic signed [srh_pkg::COUNTS_W-1:0] counts,
  input  logic [srh_pkg::TIME_W-1:0]        time_seconds,
  input  logic [srh_pkg::INDEX_W-1:0]       read_index,
  output srh_pkg::stat_t                    stat,
  output logic                              done,
  output logic                              accepted,
  output logic                              scrolled,
  output logic [srh_pkg::INDEX_W-1:0]       bin_index,
  output logic [srh_pkg::TOTAL_W-1:0]       bin_total,
  output logic signed [srh_pkg::COUNTS_W-1:0] difference,
  output logic [srh_pkg::LAST_W-1:0]        last_counts
);
  import srh_pkg::*;

  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int SUM_W = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;
  localparam logic [SUM_W-1:0] COUNT_S  = SUM_W'(BIN_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

  logic [BIN_WIDTH-1:0] mem [BIN_COUNT];

  // latched transaction
  logic                op_r;
  logic [COUNTS_W-1:0] counts_r;
  logic [TIME_W-1:0]   tsec_r;
  logic [INDEX_W-1:0]  ridx_r;

  // architectural state
  logic [TIME_W-1:0] origin;
  logic              first;
  logic [LAST_W-1:0] prev;
  logic [IDX_W-1:0]  ring_base;
  logic [IDX_W-1:0]  clr_addr;

  // working registers
  logic [TIME_W-1:0]    off32;
  logic [INDEX_W-1:0]   off;
  logic [STEP_W-1:0]    cnt;
  logic                 scrolled_r;
  logic [IDX_W-1:0]     phys;
  logic                 in_range_r;
  logic [BIN_WIDTH-1:0] rd_data;

  logic                 positive;
  logic                 event_ok;
  logic [INDEX_W-1:0]   logical;
  logic [SUM_W-1:0]     addr_sum;
  logic [SUM_W-1:0]     addr_wrap;
  logic                 addr_in_range;
  logic [TIME_W-1:0]    origin_eff;
  logic [BIN_WIDTH:0]   sum_ext;
  logic [BIN_WIDTH-1:0] sat;
  logic [WIDE_W-1:0]    sat_wide;
  logic [WIDE_W-1:0]    rd_wide;
  logic [COUNTS_W-1:0]  diff_next;
  logic [IDX_W-1:0]     rb_inc;
  logic [IDX_W-1:0]     clr_inc;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [BIN_WIDTH-1:0] wd;

  assign positive      = (counts_r != '0) && !counts_r[COUNTS_W-1];
  assign event_ok      = !op_r && positive;
  assign logical       = op_r ? ridx_r : off;
  assign addr_sum      = SUM_W'(ring_base) + SUM_W'(logical);
  assign addr_in_range = SUM_W'(logical) < COUNT_S;
  assign addr_wrap     = (addr_sum >= COUNT_S) ? addr_sum - COUNT_S : addr_sum;
  assign origin_eff    = first ? tsec_r : origin;
  assign sum_ext       = {1'b0, rd_data} + (BIN_WIDTH + 1)'(counts_r[LAST_W-1:0]);
  assign sat           = sum_ext[BIN_WIDTH] ? '1 : sum_ext[BIN_WIDTH-1:0];
  assign sat_wide      = WIDE_W'(sat);
  assign rd_wide       = WIDE_W'(rd_data);
  assign diff_next     = (prev != '0) ? counts_r - {1'b0, prev} : '0;
  assign rb_inc        = (ring_base == LAST_IDX) ? '0 : ring_base + 1'b1;
  assign clr_inc       = (clr_addr == LAST_IDX) ? '0 : clr_addr + 1'b1;

  assign stat.is_read     = op_r;
  assign stat.is_positive = positive;
  assign stat.need_scroll = off > cfg.scroll_threshold;
  assign stat.scroll_done = (cnt == '0);
  assign stat.clear_last  = (clr_addr == LAST_IDX);

  // single write port: reset sweep, scroll sweep, or bin update
  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    if (cmd.clear_mem) begin
      we = 1'b1;
    end else if (cmd.scroll_clear) begin
      we = 1'b1;
      wa = ring_base;
    end else if (cmd.finish && event_ok && in_range_r) begin
      we = 1'b1;
      wa = phys;
      wd = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.mem_read && in_range_r) rd_data <= mem[phys];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin    <= '0;
      first     <= 1'b1;
      prev      <= '0;
      ring_base <= '0;
      clr_addr  <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear_mem) clr_addr <= clr_inc;
      if (cmd.set_offset) begin
        origin <= origin_eff;
        first  <= 1'b0;
      end else if (cmd.apply_limit) begin
        if (off32 > TIME_W'(cfg.garbage_limit)) origin <= tsec_r;
      end else if (cmd.apply_scroll) begin
        origin <= origin + TIME_W'(cfg.scroll_step);
      end
      if (cmd.scroll_clear) ring_base <= rb_inc;
      if (cmd.finish && event_ok) prev <= counts_r[LAST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= operation;
      counts_r   <= counts;
      tsec_r     <= time_seconds;
      ridx_r     <= read_index;
      scrolled_r <= 1'b0;
    end
    if (cmd.set_offset) off32 <= tsec_r - origin_eff;
    if (cmd.apply_limit) begin
      off <= (off32 > TIME_W'(cfg.garbage_limit)) ? '0 : off32[INDEX_W-1:0];
    end
    if (cmd.apply_scroll) begin
      off        <= (off > INDEX_W'(cfg.scroll_step)) ?
                    off - INDEX_W'(cfg.scroll_step) : '0;
      cnt        <= cfg.scroll_step;
      scrolled_r <= 1'b1;
    end
    if (cmd.scroll_clear) cnt <= cnt - 1'b1;
    if (cmd.calc_addr) begin
      phys       <= addr_wrap[IDX_W-1:0];
      in_range_r <= addr_in_range;
    end
    if (cmd.finish) begin
      if (op_r) begin
        accepted    <= 1'b0;
        scrolled    <= 1'b0;
        bin_index   <= ridx_r;
        bin_total   <= in_range_r ? rd_wide[TOTAL_W-1:0] : '0;
        difference  <= '0;
        last_counts <= prev;
      end else if (positive) begin
        accepted    <= 1'b1;
        scrolled    <= scrolled_r;
        bin_index   <= off;
        bin_total   <= in_range_r ? sat_wide[TOTAL_W-1:0] : '0;
        difference  <= diff_next;
        last_counts <= counts_r[LAST_W-1:0];
      end else begin
        accepted    <= 1'b0;
        scrolled    <= 1'b0;
        bin_index   <= '0;
        bin_total   <= '0;
        difference  <= '0;
        last_counts <= prev;
      end
    end
  end

endmodule

// ----- sv/srh_checker.sv -----
// Port-level checks for the scrolling rate histogram, bound to the top level.
// Depends on srh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srh_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic                                accepted,
  input logic                                scrolled,
  input logic signed [srh_pkg::COUNTS_W-1:0] difference
);
  import srh_pkg::*;

  `SRH_ASSERT_CLK(a_accept_busy, clk, rst, start && !busy |=> busy, "busy low after accept")
  `SRH_ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "result shown while busy")
  `SRH_ASSERT_CLK(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `SRH_ASSERT_CLK(a_reject_quiet, clk, rst, done && !accepted |-> !scrolled && difference == '0, "unaccepted transaction shows event data")
  `SRH_ASSERT_ALWAYS(a_reset_sweep, clk, rst |=> busy && !done, "reset did not start clearing pass")

endmodule

bind scrolling_rate_histogram_core srh_checker u_srh_checker (.*);
